// ===== rtl/wildcard_byte_pattern_scanner_assert.svh =====
// Assertion macros used by the scanner checker.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define WBPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wbps assertion failed");

// Next-cycle implication, disabled while in reset.
`define WBPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wbps assertion failed");

`endif

// ===== rtl/wbps_pkg.sv =====
package wbps_pkg;

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_START = 2'd1,
		FUNC_SCAN  = 2'd2
	} wbps_func_t;

	// one pattern entry
	typedef struct packed {
		logic       wild;
		logic [7:0] value;
	} wbps_pat_t;

	localparam int PAT_W = $bits(wbps_pat_t);

	// controls broadcast to every cell
	typedef struct packed {
		logic      scan;
		logic      clear;
		logic      cfg_we;
		wbps_pat_t ld_pat;
	} wbps_ctl_t;

	// slave tdata layout
	localparam int S_TDATA_W   = 80;
	localparam int S_IDX_LSB   = 0;
	localparam int S_IDX_W     = 6;
	localparam int S_BYTE_LSB  = 6;
	localparam int S_WILD_BIT  = 14;
	localparam int S_ADDR_LSB  = 15;
	localparam int S_RSTRT_BIT = 79;

	// master tdata layout
	localparam int M_TDATA_W   = 72;
	localparam int M_FOUND_BIT = 0;
	localparam int M_ADDR_LSB  = 1;
	localparam int ADDR_W      = 64;

	localparam int CFG_W = 7;

endpackage

// ===== rtl/wbps_cell.sv =====
module wbps_cell import wbps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  wbps_ctl_t  ctl,
	input  logic [7:0] win_byte_in,
	input  logic       win_vld_in,
	input  logic       rev_we,
	input  logic       al_we,
	input  wbps_pat_t  al_cfg,
	input  logic       used,
	output logic [7:0] win_byte,
	output logic       win_vld,
	output wbps_pat_t  rev_pat,
	output logic       hit
);

	logic [7:0] win_byte_q;
	logic       win_vld_q;
	wbps_pat_t  rev_q;
	wbps_pat_t  al_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_vld_q <= 1'b0;
		end else if (ctl.clear) begin
			win_vld_q <= 1'b0;
		end else if (ctl.scan) begin
			win_vld_q <= win_vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan) begin
			win_byte_q <= win_byte_in;
		end
		if (rev_we) begin
			rev_q <= ctl.ld_pat;
		end
		// realign on a length write, else take a load aimed at this slot
		if (ctl.cfg_we) begin
			al_q <= al_cfg;
		end else if (al_we) begin
			al_q <= ctl.ld_pat;
		end
	end

	assign win_byte = win_byte_q;
	assign win_vld  = win_vld_q;
	assign rev_pat  = rev_q;
	assign hit      = !used || (win_vld_q && (al_q.wild || (win_byte_q == al_q.value)));

endmodule

// ===== rtl/wildcard_byte_pattern_scanner.sv =====
// Wildcard byte pattern scanner. Takes one word per cycle and returns one result word for
// every input word; the result is registered in stage s1, in stage s2 and in the output
// register. While a result waits on the output, the input is held off and the whole row
// holds with it. A row of MAX_PATTERN cells holds the byte window (newest in cell 0,
// shifting one cell per scan word), a reversed copy of the pattern and a copy aligned to
// the current length, so every position is compared in parallel; the cell hits are ANDed
// in groups of eight into a register, then combined with the held result. A length write
// realigns the pattern copy through a barrel shifter in the same cycle. Only the first
// match after a start word is reported; its address holds until the next start.
module wildcard_byte_pattern_scanner import wbps_pkg::*; #(
	parameter int MAX_PATTERN = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// entry_index, byte_value, is_wildcard, byte_address, region_start
	input  logic [S_TDATA_W-1:0] s_tdata,
	// func
	input  logic [1:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// match_found, match_address, zero fill
	output logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam int SW = $clog2(MAX_PATTERN);
	localparam int NG = (MAX_PATTERN + 7) / 8;

	logic              adv;
	logic              acc;
	logic              ld;
	wbps_ctl_t         ctl;
	logic [S_IDX_W-1:0] ld_idx;
	logic [7:0]        in_byte;
	logic [ADDR_W-1:0] in_addr;
	logic              in_rstart;

	logic [LW-1:0]     eff_q;
	logic [LW-1:0]     eff_new;
	logic [SW-1:0]     shift_new;

	logic [7:0]        win_byte [MAX_PATTERN];
	logic              win_vld  [MAX_PATTERN];
	wbps_pat_t         rev_pat  [MAX_PATTERN];
	logic [NG*8-1:0]   hits;
	logic [MAX_PATTERN*PAT_W-1:0] rev_vec;
	logic [MAX_PATTERN*PAT_W-1:0] al_vec;

	logic              vld_s1;
	logic [1:0]        func_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              vld_s2;
	logic [1:0]        func_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [NG-1:0]     grp_s2;

	logic              m_tvalid_q;
	logic              found_q;
	logic [ADDR_W-1:0] found_addr_q;

	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv;
	assign acc      = s_tvalid && adv;

	assign ld_idx    = s_tdata[S_IDX_LSB +: S_IDX_W];
	assign in_byte   = s_tdata[S_BYTE_LSB +: 8];
	assign in_addr   = s_tdata[S_ADDR_LSB +: ADDR_W];
	assign in_rstart = s_tdata[S_RSTRT_BIT];

	assign ld               = acc && (s_tuser == FUNC_LOAD);
	assign ctl.scan         = acc && (s_tuser == FUNC_SCAN);
	assign ctl.clear        = acc && (s_tuser == FUNC_START);
	assign ctl.cfg_we       = cfg_we;
	assign ctl.ld_pat.wild  = s_tdata[S_WILD_BIT];
	assign ctl.ld_pat.value = in_byte;

	// clamp the length into 1 .. MAX_PATTERN
	always_comb begin
		priority if (cfg_wdata == '0) begin
			eff_new = LW'(1);
		end else if (int'(cfg_wdata) > MAX_PATTERN) begin
			eff_new = LW'(MAX_PATTERN);
		end else begin
			eff_new = LW'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_q <= LW'(1);
		end else if (cfg_we) begin
			eff_q <= eff_new;
		end
	end

	// aligned slot k holds pattern entry len-1-k, reversed slot k holds entry MAX-1-k
	assign shift_new = SW'(MAX_PATTERN - int'(eff_new));
	assign al_vec    = rev_vec >> (PAT_W * int'(shift_new));

	genvar k;
	generate
		for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
			logic [7:0] byte_in;
			logic       vld_in;
			logic       rev_we;
			logic       al_we;
			logic       used;
			logic       hit;

			if (k == 0) begin : g_head
				assign byte_in = in_byte;
				assign vld_in  = 1'b1;
			end else begin : g_link
				assign byte_in = win_byte[k-1];
				// a region start leaves only the new byte valid
				assign vld_in  = !in_rstart && win_vld[k-1];
			end

			assign rev_we = ld && (int'(ld_idx) == MAX_PATTERN - 1 - k);
			assign al_we  = ld && (int'(ld_idx) + k == int'(eff_q) - 1);
			assign used   = (k < int'(eff_q));
			assign rev_vec[k*PAT_W +: PAT_W] = rev_pat[k];
			assign hits[k] = hit;

			wbps_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.win_byte_in (byte_in),
				.win_vld_in  (vld_in),
				.rev_we      (rev_we),
				.al_we       (al_we),
				.al_cfg      (wbps_pat_t'(al_vec[k*PAT_W +: PAT_W])),
				.used        (used),
				.win_byte    (win_byte[k]),
				.win_vld     (win_vld[k]),
				.rev_pat     (rev_pat[k]),
				.hit         (hit)
			);
		end
		if (NG*8 > MAX_PATTERN) begin : g_pad
			assign hits[NG*8-1:MAX_PATTERN] = '1;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (acc) begin
				func_s1 <= s_tuser;
				addr_s1 <= in_addr;
			end
			func_s2 <= func_s1;
			addr_s2 <= addr_s1;
			for (int g = 0; g < NG; g++) begin
				grp_s2[g] <= &hits[g*8 +: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q   <= 1'b0;
			found_q      <= 1'b0;
			found_addr_q <= '0;
		end else if (adv) begin
			m_tvalid_q <= vld_s2;
			if (vld_s2) begin
				unique case (func_s2)
					FUNC_START: begin
						found_q      <= 1'b0;
						found_addr_q <= '0;
					end
					FUNC_SCAN: begin
						// keep the first match only
						if (!found_q && (&grp_s2)) begin
							found_q      <= 1'b1;
							found_addr_q <= addr_s2 - (ADDR_W'(eff_q) - ADDR_W'(1));
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W - ADDR_W - 1){1'b0}}, found_addr_q, found_q};

endmodule

// ===== rtl/wbps_checker.sv =====
`include "wildcard_byte_pattern_scanner_assert.svh"

module wbps_checker import wbps_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// hold a stalled result word
	`WBPS_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`WBPS_ASSERT_NXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))

	// no match means a zero address
	`WBPS_ASSERT_IMP(a_addr_zero, clk, arst_n, m_tvalid && !m_tdata[M_FOUND_BIT], m_tdata[M_ADDR_LSB +: ADDR_W] == '0)

	// input is only throttled by a waiting result
	`WBPS_ASSERT_IMP(a_ready_free, clk, arst_n, !m_tvalid, s_tready)

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import wbps_pkg::*;

	localparam int         MAX_ENTRIES  = 64;
	localparam logic [1:0] FUNC_UNUSED  = 2'd3;
	localparam int         TARGET_WORDS = 1750;

	typedef struct {
		logic        found;
		logic [63:0] addr;
	} match_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	// entry_index, byte_value, is_wildcard, byte_address, region_start
	logic [S_TDATA_W-1:0] s_tdata;
	// func
	logic [1:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	// match_found, match_address, zero fill
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_we;
	logic [CFG_W-1:0]     cfg_wdata;

	// predictor state
	logic [7:0]  pat_byte     [MAX_ENTRIES];
	logic        pat_wild     [MAX_ENTRIES];
	logic [7:0]  window_bytes [MAX_ENTRIES];
	int          window_fill;
	logic        found_flag;
	logic [63:0] found_addr;
	logic [6:0]  length_reg;

	match_result_t pending_matches[$];
	match_result_t head_match;

	int error_count;
	int words_sent;
	int ready_hold;
	bit calm_sender;
	bit calm_receiver;

	wildcard_byte_pattern_scanner #(
		.MAX_PATTERN(MAX_ENTRIES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int active_length(logic [6:0] code);
		if (code == 7'd0)
			return 1;
		if (code > MAX_ENTRIES)
			return MAX_ENTRIES;
		return code;
	endfunction

	function automatic void predict_match(logic [1:0] func, logic [5:0] idx, logic [7:0] val,
			logic wild, logic [63:0] addr, logic rstart);
		int len;
		bit hit;
		match_result_t res;
		len = active_length(length_reg);
		case (func)
			FUNC_LOAD: begin
				pat_byte[idx] = val;
				pat_wild[idx] = wild;
			end
			FUNC_START: begin
				window_fill = 0;
				found_flag = 1'b0;
				found_addr = '0;
			end
			FUNC_SCAN: begin
				if (rstart)
					window_fill = 0;
				for (int k = MAX_ENTRIES - 1; k > 0; k--)
					window_bytes[k] = window_bytes[k - 1];
				window_bytes[0] = val;
				if (window_fill < MAX_ENTRIES)
					window_fill++;
				if (!found_flag && window_fill >= len) begin
					hit = 1'b1;
					// entry j lines up with the byte len-1-j positions back
					for (int j = 0; j < len; j++)
						if (!pat_wild[j] && window_bytes[len - 1 - j] != pat_byte[j])
							hit = 1'b0;
					if (hit) begin
						found_flag = 1'b1;
						found_addr = addr - 64'(len - 1);
					end
				end
			end
			default: ;
		endcase
		res.found = found_flag;
		res.addr = found_addr;
		pending_matches.push_back(res);
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm_sender)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_word(logic [1:0] func, logic [5:0] idx, logic [7:0] val, logic wild,
			logic [63:0] addr, logic rstart);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {rstart, addr, wild, val, idx};
		s_tuser <= func;
		do @(posedge clk); while (!s_tready);
		predict_match(func, idx, val, wild, addr, rstart);
		if (func != FUNC_UNUSED)
			words_sent++;
	endtask

	task automatic load_entry(logic [5:0] idx, logic [7:0] val, logic wild);
		send_word(FUNC_LOAD, idx, val, wild, {$urandom, $urandom}, 1'($urandom));
	endtask

	task automatic send_start();
		send_word(FUNC_START, 6'($urandom), 8'($urandom), 1'($urandom), {$urandom, $urandom},
			1'($urandom));
	endtask

	task automatic send_unused();
		send_word(FUNC_UNUSED, 6'($urandom), 8'($urandom), 1'($urandom), {$urandom, $urandom},
			1'($urandom));
	endtask

	task automatic scan_byte(logic [7:0] val, logic [63:0] addr, logic rstart);
		send_word(FUNC_SCAN, 6'($urandom), val, 1'($urandom), addr, rstart);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_matches.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_length(logic [6:0] code);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= code;
		@(posedge clk);
		length_reg = code;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// reset length of one, single-entry matches, hold after match, unused func
	task automatic test_single_entry();
		load_entry(6'd0, 8'hFF, 1'b0);
		send_start();
		scan_byte(8'h00, 64'd5, 1'b1);
		scan_byte(8'hFF, 64'd6, 1'b0);
		scan_byte(8'hFF, 64'd7, 1'b0);
		send_unused();
		send_start();
		scan_byte(8'hFF, '1, 1'b1);
	endtask

	// wildcard entry, address wrap below zero, region break inside a match
	task automatic test_wildcard_wrap();
		write_length(7'd3);
		load_entry(6'd0, 8'h00, 1'b0);
		load_entry(6'd1, 8'hA5, 1'b1);
		load_entry(6'd2, 8'h80, 1'b0);
		send_start();
		scan_byte(8'h00, 64'd0, 1'b1);
		scan_byte(8'h55, 64'd1, 1'b0);
		scan_byte(8'h80, 64'd2, 1'b0);
		send_start();
		scan_byte(8'h00, '1, 1'b1);
		scan_byte(8'h11, 64'd0, 1'b0);
		scan_byte(8'h80, 64'd1, 1'b0);
		send_start();
		scan_byte(8'h00, 64'd40, 1'b1);
		scan_byte(8'h12, 64'd41, 1'b0);
		scan_byte(8'h80, 64'd42, 1'b1);
	endtask

	// length zero acts as one; length above the maximum acts as the maximum
	task automatic test_length_extremes();
		logic [63:0] base;
		write_length(7'd0);
		send_start();
		scan_byte(8'h01, 64'd2, 1'b1);
		scan_byte(8'h00, 64'd3, 1'b0);
		for (int i = 0; i < MAX_ENTRIES; i++)
			load_entry(6'(i), 8'(i), !(i == 0 || i == MAX_ENTRIES - 1));
		write_length(7'd127);
		send_start();
		base = {$urandom, $urandom};
		for (int k = 0; k < MAX_ENTRIES; k++)
			scan_byte((k == MAX_ENTRIES - 1) ? 8'(k) : (k == 0) ? 8'h00 : 8'($urandom),
				base + 64'(k), k == 0);
	endtask

	function automatic logic [63:0] pick_base(int span);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 64'($urandom_range(0, span));
		if (r == 1)
			return '1 - 64'($urandom_range(0, 150));
		return {$urandom, $urandom};
	endfunction

	// regions with planted copies of the pattern, near misses and noise
	task automatic test_random_regions();
		int r, span, regions, rlen, off, break_at;
		bit plant, narrow;
		logic [6:0] code;
		logic [63:0] base;
		logic [7:0] b;
		while (words_sent < TARGET_WORDS) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				code = 7'($urandom_range(1, 8));
			else if (r < 80)
				code = 7'($urandom_range(9, 24));
			else if (r < 86)
				code = 7'($urandom_range(25, 63));
			else if (r < 90)
				code = 7'd64;
			else if (r < 95)
				code = 7'd0;
			else
				code = 7'($urandom_range(65, 127));
			calm_sender = ($urandom_range(0, 3) == 0);
			calm_receiver = ($urandom_range(0, 3) == 0);
			write_length(code);
			span = active_length(code);
			narrow = $urandom_range(0, 1);
			for (int i = 0; i < span; i++)
				load_entry(6'(i), narrow ? 8'($urandom_range(0, 3)) : 8'($urandom),
					$urandom_range(0, 3) == 0);
			send_start();
			regions = $urandom_range(2, 6);
			for (int g = 0; g < regions; g++) begin
				if ($urandom_range(0, 2) == 0)
					send_start();
				plant = $urandom_range(0, 9) < 7;
				rlen = plant ? span + $urandom_range(0, 12) : $urandom_range(1, span + 12);
				off = $urandom_range(0, rlen - span);
				// cut the region inside the planted copy now and then
				break_at = ($urandom_range(0, 9) == 0 && span > 1) ?
					off + $urandom_range(1, span - 1) : -1;
				base = pick_base(span);
				for (int k = 0; k < rlen; k++) begin
					r = $urandom_range(0, 99);
					if (r < 2)
						load_entry(6'($urandom), 8'($urandom), 1'($urandom));
					else if (r < 4)
						send_unused();
					else if (r < 5)
						send_start();
					if (plant && k >= off && k < off + span && !pat_wild[k - off])
						b = pat_byte[k - off];
					else if (narrow || $urandom_range(0, 1))
						b = pat_byte[$urandom_range(0, span - 1)];
					else
						b = 8'($urandom);
					scan_byte(b, base + 64'(k), k == 0 || k == break_at);
				end
			end
		end
	endtask

	// result side: random stalls, mostly short
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else if (calm_receiver || $urandom_range(0, 3) != 0) begin
			m_tready <= 1'b1;
			ready_hold = $urandom_range(0, 6);
		end else begin
			m_tready <= 1'b0;
			ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
				$urandom_range(0, 2);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_matches.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result word found=%0b addr=%h", $realtime,
					m_tdata[M_FOUND_BIT], m_tdata[M_ADDR_LSB +: ADDR_W]);
			end else begin
				head_match = pending_matches.pop_front();
				if (m_tdata[M_FOUND_BIT] !== head_match.found) begin
					error_count++;
					$display("%0t: match_found expected %0b actual %0b", $realtime,
						head_match.found, m_tdata[M_FOUND_BIT]);
				end
				if (m_tdata[M_ADDR_LSB +: ADDR_W] !== head_match.addr) begin
					error_count++;
					$display("%0t: match_address expected %h actual %h", $realtime,
						head_match.addr, m_tdata[M_ADDR_LSB +: ADDR_W]);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		error_count = 0;
		words_sent = 0;
		ready_hold = 0;
		calm_sender = 1'b0;
		calm_receiver = 1'b0;
		window_fill = 0;
		found_flag = 1'b0;
		found_addr = '0;
		length_reg = 7'd1;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			pat_byte[i] = '0;
			pat_wild[i] = 1'b0;
			window_bytes[i] = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_single_entry();
		test_wildcard_wrap();
		test_length_extremes();
		test_random_regions();

		wait_drained();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
